// ----- sv/qdc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the dual quadrature counter.
// No dependencies.
package qdc_pkg;

  localparam int CntW = 32;
  localparam int WinW = 16;
  localparam int OutW = 32;

  localparam logic [WinW-1:0] WinReset = WinW'(20);

  // action codes
  localparam logic ActPin  = 1'b0;
  localparam logic ActTick = 1'b1;

  typedef logic signed [CntW-1:0] cnt_t;
  typedef logic [WinW-1:0]        win_t;

  // per-beat control fanned out to both channels
  typedef struct packed {
    logic pin_evt;
    logic close;
  } qdc_ctl_t;

endpackage

// ----- sv/qdc_window.sv -----
`timescale 1ns / 1ps
// Tick counter and window length register; flags the tick that closes a window.
// Depends on qdc_pkg.
module qdc_window import qdc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  win_t cfg_wdata_i,
  input  logic tick_i,
  output logic close_o
);

  win_t window_q;
  win_t ticks_q, ticks_d, ticks_inc;

  always_comb begin
    ticks_inc = ticks_q + win_t'(1);
    close_o   = tick_i && (ticks_inc >= window_q);
    ticks_d   = ticks_q;
    if (tick_i) begin
      ticks_d = close_o ? '0 : ticks_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WinReset;
      ticks_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      ticks_q <= ticks_d;
    end
  end

endmodule

// ----- sv/qdc_channel.sv -----
`timescale 1ns / 1ps
// One x4 quadrature channel: running count, window snapshot and speed.
// Depends on qdc_pkg.
module qdc_channel import qdc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  qdc_ctl_t   ctl_i,
  input  logic [1:0] chg_i,
  input  logic [1:0] lvl_i,
  output cnt_t       count_d_o,
  output cnt_t       rate_d_o
);

  cnt_t count_q, count_d;
  cnt_t snap_q, snap_d;
  cnt_t rate_q, rate_d;
  logic same;
  logic up;
  logic dn;

  always_comb begin
    same = (lvl_i[0] == lvl_i[1]);
    // both phases changed: +1 and -1 cancel
    up = (chg_i == 2'b01 && same) || (chg_i == 2'b10 && !same);
    dn = (chg_i == 2'b01 && !same) || (chg_i == 2'b10 && same);
    count_d = count_q;
    snap_d  = snap_q;
    rate_d  = rate_q;
    if (ctl_i.pin_evt) begin
      if (up) begin
        count_d = count_q + cnt_t'(1);
      end else if (dn) begin
        count_d = count_q - cnt_t'(1);
      end
    end
    if (ctl_i.close) begin
      rate_d = count_q - snap_q;
      snap_d = count_q;
    end
  end

  assign count_d_o = count_d;
  assign rate_d_o  = rate_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      snap_q  <= '0;
      rate_q  <= '0;
    end else if (adv_i) begin
      count_q <= count_d;
      snap_q  <= snap_d;
      rate_q  <= rate_d;
    end
  end

endmodule

// ----- sv/dual_quadrature_counter_with_speed.sv -----
`timescale 1ns / 1ps
// Dual x4 quadrature counter with windowed speed: top level.
// Each accepted input beat passes through the input register, then the result register.
// Throughput: one beat per cycle; the input register drains whenever the result register
// is empty or being taken, so stall only rises under output back-pressure.
// Reset: counts, snapshots, speeds and tick counter clear; window length resets to 20.
// Depends on qdc_pkg, qdc_window, qdc_channel.
module dual_quadrature_counter_with_speed import qdc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [WinW-1:0]   cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              action_i,
  input  logic [3:0]        changed_pins_i,
  input  logic [3:0]        pin_state_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic signed [OutW-1:0] position_one_o,
  output logic signed [OutW-1:0] position_two_o,
  output logic signed [OutW-1:0] speed_one_o,
  output logic signed [OutW-1:0] speed_two_o,
  output logic              speed_updated_o
);

  logic       in_vld_q;
  logic       act_q;
  logic [3:0] chg_q;
  logic [3:0] lvl_q;
  logic       adv;
  logic       close;
  qdc_ctl_t   ctl;
  cnt_t       cnt1_d, cnt2_d, rate1_d, rate2_d;

  logic                   out_vld_q;
  logic signed [OutW-1:0] pos1_q, pos2_q, spd1_q, spd2_q;
  logic                   upd_q;

  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // hold the beat while stalled
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      act_q <= action_i;
      chg_q <= changed_pins_i;
      lvl_q <= pin_state_i;
    end
  end

  qdc_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .tick_i      (adv && act_q == ActTick),
    .close_o     (close)
  );

  assign ctl.pin_evt = adv && act_q == ActPin;
  assign ctl.close   = close;

  qdc_channel u_chan_one (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .ctl_i     (ctl),
    .chg_i     (chg_q[1:0]),
    .lvl_i     (lvl_q[1:0]),
    .count_d_o (cnt1_d),
    .rate_d_o  (rate1_d)
  );

  qdc_channel u_chan_two (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .ctl_i     (ctl),
    .chg_i     (chg_q[3:2]),
    .lvl_i     (lvl_q[3:2]),
    .count_d_o (cnt2_d),
    .rate_d_o  (rate2_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // sign-extend or cut the counter width to the port width
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos1_q <= OutW'(cnt1_d);
      pos2_q <= OutW'(cnt2_d);
      spd1_q <= OutW'(rate1_d);
      spd2_q <= OutW'(rate2_d);
      upd_q  <= close;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign position_one_o  = pos1_q;
  assign position_two_o  = pos2_q;
  assign speed_one_o     = spd1_q;
  assign speed_two_o     = spd2_q;
  assign speed_updated_o = upd_q;

endmodule
